FILE: src/heading_window_switch_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// Each macro expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef HEADING_WINDOW_SWITCH_CORE_ASSERT_SVH
`define HEADING_WINDOW_SWITCH_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define HWS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define HWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/hws_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hws_pkg
// Shared constants, types and helpers of the heading window switch.
// ---------------------------------------------------------------------------
package hws_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SAMPLE_BITS  = 16;
	localparam int N_CELLS      = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam int SCALE_SH     = 24 - SAMPLE_BITS;

	localparam int CX_W   = 27;
	localparam int Z_W    = 25;
	localparam int ATAN_W = 22;

	localparam logic [16:0] FULL_Q8     = 17'd92160;
	localparam logic [16:0] HALF_Q8     = 17'd46080;
	localparam logic [22:0] QUARTER_Q16 = 23'd5898240;

	// atan(2^-i) in degrees, Q16
	localparam logic [ATAN_W-1:0] ATAN_Q16 [24] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0
	};

	localparam logic [1:0] REG_ARC_START = 2'd0;
	localparam logic [1:0] REG_ARC_END   = 2'd1;
	localparam logic [1:0] REG_HYST      = 2'd2;

	localparam logic [8:0] ARC_START_RST = 9'd90;
	localparam logic [8:0] ARC_END_RST   = 9'd180;
	localparam logic [8:0] HYST_RST      = 9'd5;

	localparam logic [1:0] TR_NONE = 2'd0;
	localparam logic [1:0] TR_ON   = 2'd1;
	localparam logic [1:0] TR_OFF  = 2'd2;

	typedef struct packed {
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic signed [Z_W-1:0]  z;
	} hws_vec_t;

	typedef struct packed {
		logic       start_we;
		logic       end_we;
		logic [8:0] data;
	} hws_cfg_wr_t;

	typedef struct packed {
		logic [1:0]  tr;
		logic        active;
		logic [16:0] heading;
	} hws_res_t;

	// fold a bound in -511..1022 into 0..359
	function automatic logic [8:0] wrap360(input logic signed [11:0] v);
		logic signed [11:0] t;
		t = v;
		if (t < 12'sd0) t = t + 12'sd360;
		if (t < 12'sd0) t = t + 12'sd360;
		if (t >= 12'sd360) t = t - 12'sd360;
		if (t >= 12'sd360) t = t - 12'sd360;
		return t[8:0];
	endfunction

endpackage

FILE: src/hws_cordic_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hws_cordic_cell
// One vectoring CORDIC micro-rotation, registered; step is tied constant.
// ---------------------------------------------------------------------------
module hws_cordic_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [4:0]       step,
	input  logic             in_vld,
	input  hws_pkg::hws_vec_t in_vec,
	output logic             out_vld,
	output hws_pkg::hws_vec_t out_vec
);
	import hws_pkg::*;

	logic signed [CX_W-1:0] cx, cy, dx, dy;
	logic signed [Z_W-1:0]  z, at;
	hws_vec_t               nxt;
	logic                   vld_q;
	hws_vec_t               vec_q;

	assign cx = in_vec.cx;
	assign cy = in_vec.cy;
	assign z  = in_vec.z;
	assign dx = cy >>> step;
	assign dy = cx >>> step;
	assign at = signed'(Z_W'(ATAN_Q16[step]));

	// rotate towards the x axis
	always_comb begin
		if (!cy[CX_W-1]) begin
			nxt.cx = cx + dx;
			nxt.cy = cy - dy;
			nxt.z  = z + at;
		end else begin
			nxt.cx = cx - dx;
			nxt.cy = cy + dy;
			nxt.z  = z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			vec_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign out_vec = vec_q;

endmodule

FILE: src/hws_heading.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hws_heading
// Clamp and round the CORDIC angle, restore the quadrant, form the heading.
// ---------------------------------------------------------------------------
module hws_heading (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic signed [hws_pkg::Z_W-1:0] in_z,
	input  logic                        x_neg,
	input  logic                        y_neg,
	output logic                        hd_vld,
	output logic [16:0]                 hd_q8
);
	import hws_pkg::*;

	logic [22:0] zc;
	logic [23:0] zr;
	logic [16:0] phi, a, af;
	logic        vld_q;
	logic [16:0] hd_q;

	always_comb begin
		if (in_z[Z_W-1]) begin
			zc = '0;
		end else if (in_z > signed'(Z_W'(QUARTER_Q16))) begin
			zc = QUARTER_Q16;
		end else begin
			zc = in_z[22:0];
		end
	end

	// round half up to Q8
	assign zr  = {1'b0, zc} + 24'd128;
	assign phi = {2'b0, zr[22:8]};

	always_comb begin
		if (!y_neg) begin
			a = x_neg ? (FULL_Q8 - phi) : phi;
		end else begin
			a = x_neg ? (HALF_Q8 + phi) : (HALF_Q8 - phi);
		end
		af = (a >= FULL_Q8) ? (a - FULL_Q8) : a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			hd_q <= FULL_Q8 - af;
		end
	end

	assign hd_vld = vld_q;
	assign hd_q8  = hd_q;

endmodule

FILE: src/hws_window.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hws_window
// Active flag and current arc; reports entry into and exit from the arc.
// ---------------------------------------------------------------------------
module hws_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hws_pkg::hws_cfg_wr_t cfg_wr,
	input  logic [8:0]           arc_start,
	input  logic [8:0]           arc_end,
	input  logic [8:0]           hyst,
	input  logic                 in_vld,
	input  logic [16:0]          in_heading,
	output logic                 res_vld,
	output hws_pkg::hws_res_t    res
);
	import hws_pkg::*;

	logic        active_q;
	logic [8:0]  win_start_q, win_end_q;
	logic        res_vld_q;
	hws_res_t    res_q;
	logic [16:0] s_q8, e_q8;
	logic        in_arc;
	logic [8:0]  on_start, on_end, off_start, off_end;

	assign s_q8 = {win_start_q, 8'b0};
	assign e_q8 = {win_end_q, 8'b0};

	// a start beyond the end means the arc wraps through north
	always_comb begin
		if (win_start_q <= win_end_q) begin
			in_arc = (in_heading > s_q8) && (in_heading < e_q8);
		end else begin
			in_arc = (in_heading > s_q8) || (in_heading < e_q8);
		end
	end

	assign on_start  = wrap360(signed'(12'(arc_start)) - signed'(12'(hyst)));
	assign on_end    = wrap360(signed'(12'(arc_end)) + signed'(12'(hyst)));
	assign off_start = wrap360(signed'(12'(arc_start)) + signed'(12'(hyst)));
	assign off_end   = wrap360(signed'(12'(arc_end)) - signed'(12'(hyst)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			win_start_q <= ARC_START_RST;
			win_end_q   <= ARC_END_RST;
			res_vld_q   <= 1'b0;
		end else begin
			res_vld_q <= in_vld;
			if (cfg_wr.start_we) win_start_q <= cfg_wr.data;
			if (cfg_wr.end_we) win_end_q <= cfg_wr.data;
			if (in_vld) begin
				if (in_arc && !active_q) begin
					active_q    <= 1'b1;
					win_start_q <= on_start;
					win_end_q   <= on_end;
				end else if (!in_arc && active_q) begin
					active_q    <= 1'b0;
					win_start_q <= off_start;
					win_end_q   <= off_end;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			res_q.heading <= in_heading;
			res_q.active  <= in_arc;
			if (in_arc && !active_q) begin
				res_q.tr <= TR_ON;
			end else if (!in_arc && active_q) begin
				res_q.tr <= TR_OFF;
			end else begin
				res_q.tr <= TR_NONE;
			end
		end
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule

FILE: src/heading_window_switch_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heading_window_switch_core
// Compass heading from a magnetometer sample, with a hysteresis arc switch.
// ---------------------------------------------------------------------------
// Input channel s_*: one word per sample, axis_x in bits 15:0 and axis_y in
// bits 31:16, both two's complement. Output channel m_*: one word per
// sample, heading in Q8 degrees over (0,360], the active flag and a one-shot
// transition code (none, became active, became inactive).
// The heading runs through a row of CORDIC cells, one micro-rotation per
// cell per cycle, then a rounding/quadrant stage and the arc stage. A sample
// passes the input register, the cells, the heading and arc registers and
// the output register on its way to m_*; the block holds one sample at a
// time, so the next sample is taken the cycle after the result is taken.
// When the receiver stalls, the result holds on m_* and s_tready stays low.
// Reset clears the pipeline and the output, drops the active flag and
// reloads arc 90..180 degrees with 5 degrees of hysteresis. Registers are
// written over the APB port; the user must write them only while the block
// is idle, which the block itself does not enforce. Arc start is at 0x0, arc
// end at 0x4, hysteresis at 0x8. A write to a bound also reloads the arc.
// ---------------------------------------------------------------------------
module heading_window_switch_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] axis_x, [31:16] axis_y
	// heading stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [16:0] heading_q8, [17] active_now,
	                              // [19:18] transition, [23:20] zero
);
	import hws_pkg::*;

	// configuration registers
	logic [8:0]  arc_start_q, arc_end_q, hyst_q;
	logic        wr_en;
	logic [1:0]  reg_idx;
	hws_cfg_wr_t cfg_wr;

	// sample intake
	logic                              busy_q;
	logic                              in_acc;
	logic signed [SAMPLE_BITS-1:0]     x_s, y_s;
	logic signed [CX_W-1:0]            x_ext, y_ext, x_mag, y_mag;
	logic                              x_neg_q, y_neg_q;
	logic                              load_vld_q;
	hws_vec_t                          load_vec_q;

	// cell row
	logic     chain_vld [N_CELLS+1];
	hws_vec_t chain_vec [N_CELLS+1];

	// heading and arc stages
	logic        hd_vld;
	logic [16:0] hd_q8;
	logic        res_vld;
	hws_res_t    res;

	// output register
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	assign cfg_wr.start_we = wr_en && (reg_idx == REG_ARC_START);
	assign cfg_wr.end_we   = wr_en && (reg_idx == REG_ARC_END);
	assign cfg_wr.data     = pwdata[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_start_q <= ARC_START_RST;
			arc_end_q   <= ARC_END_RST;
			hyst_q      <= HYST_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ARC_START: arc_start_q <= pwdata[8:0];
				REG_ARC_END:   arc_end_q   <= pwdata[8:0];
				REG_HYST:      hyst_q      <= pwdata[8:0];
				default:       ;  // unmapped: drop the write
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ARC_START: prdata = {23'b0, arc_start_q};
			REG_ARC_END:   prdata = {23'b0, arc_end_q};
			REG_HYST:      prdata = {23'b0, hyst_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- sample intake ----------------
	// one sample in flight: take a new one only once the last result has gone
	assign s_tready = !busy_q;
	assign in_acc   = s_tvalid && s_tready;

	assign x_s   = s_tdata[SAMPLE_BITS-1:0];
	assign y_s   = s_tdata[16+SAMPLE_BITS-1:16];
	assign x_ext = CX_W'(x_s);
	assign y_ext = CX_W'(y_s);
	assign x_mag = x_s[SAMPLE_BITS-1] ? -x_ext : x_ext;
	assign y_mag = y_s[SAMPLE_BITS-1] ? -y_ext : y_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			load_vld_q <= 1'b0;
		end else begin
			load_vld_q <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				busy_q <= 1'b0;
			end
		end
	end

	// scale magnitudes to 2^23 full scale; cordic x takes |y|, cordic y takes |x|
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_neg_q       <= x_s[SAMPLE_BITS-1];
			y_neg_q       <= y_s[SAMPLE_BITS-1];
			load_vec_q.cx <= y_mag <<< SCALE_SH;
			load_vec_q.cy <= x_mag <<< SCALE_SH;
			load_vec_q.z  <= '0;
		end
	end

	// ---------------- cell row ----------------
	assign chain_vld[0] = load_vld_q;
	assign chain_vec[0] = load_vec_q;

	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		hws_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (5'(g)),
			.in_vld  (chain_vld[g]),
			.in_vec  (chain_vec[g]),
			.out_vld (chain_vld[g+1]),
			.out_vec (chain_vec[g+1])
		);
	end

	// ---------------- heading and arc ----------------
	hws_heading u_heading (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (chain_vld[N_CELLS]),
		.in_z   (chain_vec[N_CELLS].z),
		.x_neg  (x_neg_q),
		.y_neg  (y_neg_q),
		.hd_vld (hd_vld),
		.hd_q8  (hd_q8)
	);

	hws_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.arc_start  (arc_start_q),
		.arc_end    (arc_end_q),
		.hyst       (hyst_q),
		.in_vld     (hd_vld),
		.in_heading (hd_q8),
		.res_vld    (res_vld),
		.res        (res)
	);

	// ---------------- output register ----------------
	// hold the word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_vld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			m_tdata_q <= {4'b0, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: src/hws_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hws_checker
// Port-level checks of the heading window switch, bound to the top level.
// ---------------------------------------------------------------------------
`include "heading_window_switch_core_assert.svh"

module hws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import hws_pkg::*;

	// stalled word holds
	`HWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

	// no new sample while a result is pending
	`HWS_ASSERT_SAME(a_one_in_flight, m_tvalid, !s_tready, "sample taken while result pending")

	// heading within (0,360] and padding clear
	`HWS_ASSERT_SAME(a_heading_range, m_tvalid, (m_tdata[16:0] != 17'd0) && (m_tdata[16:0] <= FULL_Q8) && (m_tdata[23:20] == 4'd0), "heading out of range")

	// transition code agrees with the flag
	`HWS_ASSERT_SAME(a_tr_flag, m_tvalid, (m_tdata[19:18] != 2'd3) && ((m_tdata[19:18] != TR_ON) || m_tdata[17]) && ((m_tdata[19:18] != TR_OFF) || !m_tdata[17]), "transition disagrees with active flag")

	// drop ready once a sample has been taken
	`HWS_ASSERT_NEXT(a_taken_busy, s_tvalid && s_tready, !s_tready, "ready stayed high after a sample was taken")

endmodule

bind heading_window_switch_core hws_checker u_hws_checker (.*);

FILE: sim/heading_window_switch_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heading_window_switch_checker
// Watches the APB port and both streams of the heading window switch. Keeps
// its own copy of the arc registers and the switch state, predicts each
// heading word from the accepted sample and compares it with the next word
// taken from the block. Register reads are checked against the copy.
// ---------------------------------------------------------------------------
module heading_window_switch_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] axis_x, [31:16] axis_y
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [16:0] heading_q8, [17] active_now,
	                               // [19:18] transition, [23:20] zero
	output int          fail_count,
	output int          pending
);
	import hws_pkg::*;

	localparam int     ROT_STEPS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam longint DEG360_Q8  = 92160;
	localparam longint DEG180_Q8  = 46080;
	localparam longint DEG90_Q16  = 5898240;

	// atan(2^-i) in degrees, Q16
	longint atan_step_q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	hws_res_t heading_due [$];

	int cfg_start, cfg_end, cfg_hyst;
	int win_lo, win_hi;
	bit on_arc;
	int faults = 0;

	function automatic int fold360(input int v);
		int r;
		r = v % 360;
		if (r < 0)
			r += 360;
		return r;
	endfunction

	task automatic log_fault(input string text);
		faults++;
		if (faults <= 10)
			$display("%s", text);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		longint   sx, sy, cx, cy, ang, dx, dy, quad;
		int       h_q8, lo_q8, hi_q8, reg_val;
		bit       in_arc;
		logic [1:0] tr;
		hws_res_t want, got;

		if (!arst_n) begin
			cfg_start = int'(ARC_START_RST);
			cfg_end   = int'(ARC_END_RST);
			cfg_hyst  = int'(HYST_RST);
			win_lo    = cfg_start;
			win_hi    = cfg_end;
			on_arc    = 1'b0;
			heading_due.delete();
			pending    <= 0;
			fail_count <= faults;
		end else begin
			// register traffic, only ever seen while the block is idle
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_ARC_START: begin
							cfg_start = int'(pwdata[8:0]);
							win_lo    = cfg_start;
						end
						REG_ARC_END: begin
							cfg_end = int'(pwdata[8:0]);
							win_hi  = cfg_end;
						end
						REG_HYST: cfg_hyst = int'(pwdata[8:0]);
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_ARC_START: reg_val = cfg_start;
						REG_ARC_END:   reg_val = cfg_end;
						REG_HYST:      reg_val = cfg_hyst;
						default:       reg_val = 0;
					endcase
					if (prdata !== 32'(reg_val))
						log_fault($sformatf("register read at %h: expected %0d, got %h",
							paddr, reg_val, prdata));
				end
			end

			// sample accepted: work out the heading and the switch decision
			if (s_tvalid && s_tready) begin
				sx = longint'($signed(s_tdata[15:0]));
				sy = longint'($signed(s_tdata[31:16]));
				sx = (sx <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
				sy = (sy <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
				cx = (sy < 0) ? -sy : sy;
				cy = (sx < 0) ? -sx : sx;
				cx = cx <<< (24 - SAMPLE_BITS);
				cy = cy <<< (24 - SAMPLE_BITS);
				ang = 0;
				for (int i = 0; i < ROT_STEPS; i++) begin
					dx = cy >>> i;
					dy = cx >>> i;
					if (cy >= 0) begin
						cx += dx;
						cy -= dy;
						ang += atan_step_q16[i];
					end else begin
						cx -= dx;
						cy += dy;
						ang -= atan_step_q16[i];
					end
				end
				if (ang < 0)
					ang = 0;
				if (ang > DEG90_Q16)
					ang = DEG90_Q16;
				quad = (ang + 128) >>> 8;
				// restore the quadrant: y below zero is the left half
				if (sy >= 0)
					quad = (sx >= 0) ? quad : DEG360_Q8 - quad;
				else
					quad = (sx >= 0) ? DEG180_Q8 - quad : DEG180_Q8 + quad;
				if (quad >= DEG360_Q8)
					quad -= DEG360_Q8;
				h_q8 = int'(DEG360_Q8 - quad);

				lo_q8 = win_lo * 256;
				hi_q8 = win_hi * 256;
				if (win_lo <= win_hi)
					in_arc = (h_q8 > lo_q8) && (h_q8 < hi_q8);
				else
					in_arc = (h_q8 > lo_q8) || (h_q8 < hi_q8);

				tr = TR_NONE;
				if (in_arc) begin
					if (!on_arc) begin
						win_lo = fold360(cfg_start - cfg_hyst);
						win_hi = fold360(cfg_end + cfg_hyst);
						on_arc = 1'b1;
						tr     = TR_ON;
					end
				end else if (on_arc) begin
					on_arc = 1'b0;
					win_lo = fold360(cfg_start + cfg_hyst);
					win_hi = fold360(cfg_end - cfg_hyst);
					tr     = TR_OFF;
				end

				want.heading = h_q8[16:0];
				want.active  = on_arc;
				want.tr      = tr;
				heading_due.push_back(want);
			end

			// word taken from the block: compare with the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata[19:0];
				if (heading_due.size() == 0) begin
					log_fault($sformatf("heading word with nothing predicted: %h", m_tdata));
				end else begin
					want = heading_due.pop_front();
					if (got.heading !== want.heading || got.active !== want.active ||
					    got.tr !== want.tr || m_tdata[23:20] !== 4'd0)
						log_fault($sformatf({"heading word mismatch: expected heading %0d ",
							"active %0b transition %0d, got heading %0d active %0b ",
							"transition %0d pad %h"}, want.heading, want.active, want.tr,
							got.heading, got.active, got.tr, m_tdata[23:20]));
				end
			end

			pending    <= heading_due.size();
			fail_count <= faults;
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the heading window switch. Drives magnetometer
// samples and arc settings into the block; the checker beside it predicts
// and compares every heading word.
// ---------------------------------------------------------------------------
module testbench;
	import hws_pkg::*;

	// address slot with no register behind it: writes must be dropped
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int N_PHASES        = 10;
	localparam int ITEMS_PER_PHASE = 128;
	// pipeline settling time once every predicted word has arrived
	localparam int DRAIN_CYCLES    = 40;
	// receiver holds off this long once this many words have been taken
	localparam int HOLD_AT         = 500;
	localparam int HOLD_CYCLES     = 400;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [15:0] axis_x, [31:16] axis_y
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // [16:0] heading_q8, [17] active_now,
	                              // [19:18] transition, [23:20] zero

	int fail_count;
	int pending;

	// idle percentages of the sample sender and the heading receiver
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	int words_taken = 0;
	int hold_left   = 0;
	bit held        = 1'b0;

	// directed samples: zero vector, axis extremes, each quadrant, then a
	// walk into the default arc, along its widened edges and out again
	logic signed [15:0] dir_x [19] = '{
		16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0,
		-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
		16'sd1, 16'sd0, -16'sd1, 16'sd1,
		-16'sd20000, -16'sd20000, 16'sd0, -16'sd32768, 16'sd20000, 16'sd0
	};
	logic signed [15:0] dir_y [19] = '{
		16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
		-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
		16'sd0, -16'sd1, -16'sd1, 16'sd1,
		-16'sd20000, 16'sd0, -16'sd20000, -16'sd1, 16'sd0, 16'sd0
	};

	// arc settings per phase; the last phases draw theirs at random
	int set_start [7] = '{0,   360, 270, 100, 511, 0,   45};
	int set_end   [7] = '{360, 0,   90,  100, 511, 0,   300};
	int set_hyst  [7] = '{0,   5,   20,  0,   511, 360, 180};

	logic signed [15:0] edge_vals [6] = '{
		-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
	};

	heading_window_switch_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	heading_window_switch_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Heading receiver. Stall at the phase's rate; once, after HOLD_AT
	// words, hold off for a long stretch so the block fills and the
	// sender is stalled at its input.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			words_taken <= words_taken + 1;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (words_taken == HOLD_AT && !held) begin
			held      <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one sample word, idling first at the sender's rate; return at
	// the edge that takes it, leaving tvalid high for the caller.
	task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ay, ax};
		do @(posedge clk); while (!s_tready);
	endtask

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write a register with junk above bit 8, then read it back.
	task automatic set_reg(input logic [1:0] idx, input int val);
		logic [31:0] data;
		data      = $urandom;
		data[8:0] = val[8:0];
		apb_access(1'b1, idx, data);
		apb_access(1'b0, idx, 32'd0);
	endtask

	// Drop tvalid, wait for every predicted word to arrive, then let the
	// pipeline settle before anything touches the registers.
	task automatic drain;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [15:0] ax, ay;
		int pick, arc_s, arc_e, arc_h;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the three registers
		apb_access(1'b0, REG_ARC_START, 32'd0);
		apb_access(1'b0, REG_ARC_END, 32'd0);
		apb_access(1'b0, REG_HYST, 32'd0);

		// directed samples on the reset arc, no idling
		for (int k = 0; k < 19; k++)
			send_sample(dir_x[k], dir_y[k]);

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			tx_idle_pct = 0;
			rx_idle_pct <= 0;

			// a write to the spare slot must leave everything as it was
			if (p == 0)
				apb_access(1'b1, REG_SPARE, $urandom);

			if (p < 7) begin
				arc_s = set_start[p];
				arc_e = set_end[p];
				arc_h = set_hyst[p];
			end else begin
				arc_s = $urandom_range(0, 511);
				arc_e = $urandom_range(0, 511);
				arc_h = $urandom_range(0, 360);
			end
			set_reg(REG_ARC_START, arc_s);
			set_reg(REG_ARC_END, arc_e);
			set_reg(REG_HYST, arc_h);

			// rotate through no idling, sender idle, receiver stall, both
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_idle_pct <= 0;  end
				1: begin tx_idle_pct = 54; rx_idle_pct <= 0;  end
				2: begin tx_idle_pct = 0;  rx_idle_pct <= 54; end
				default: begin tx_idle_pct = 7; rx_idle_pct <= 7; end
			endcase

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					// anywhere on the full input range
					ax = 16'($urandom);
					ay = 16'($urandom);
				end else if (pick < 75) begin
					// tiny vectors, where rounding is coarse
					ax = 16'($urandom_range(8)) - 16'd4;
					ay = 16'($urandom_range(8)) - 16'd4;
				end else if (pick < 85) begin
					// on an axis: headings land on whole quarter turns
					if ($urandom_range(1)) begin
						ax = 16'($urandom);
						ay = '0;
					end else begin
						ax = '0;
						ay = 16'($urandom);
					end
				end else if (pick < 95) begin
					ax = edge_vals[$urandom_range(5)];
					ay = edge_vals[$urandom_range(5)];
				end else begin
					// diagonals: octant boundaries
					ax = 16'($urandom);
					ay = $urandom_range(1) ? ax : -ax;
				end
				send_sample(ax, ay);
			end
		end

		drain();
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/hws_pkg.sv
src/hws_cordic_cell.sv
src/hws_heading.sv
src/hws_window.sv
src/heading_window_switch_core.sv
src/hws_checker.sv
sim/heading_window_switch_checker.sv
sim/testbench.sv
